FILE: src/htvs_pkg.sv
// ----------------------------------------------------------------------------
// htvs_pkg
// Shared types and constants of the terrain vertex stream: register indexes,
// the biome palette, the job word passed from the front to the back.
// ----------------------------------------------------------------------------
package htvs_pkg;

	// Widest column and row index over the supported grid range
	localparam int COL_W = 12;
	localparam int ROW_W = 16;

	// Configuration register indexes
	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_XY_SCALE    = 3'd2;
	localparam logic [2:0] CFG_Z_SCALE     = 3'd3;
	localparam logic [2:0] CFG_WATER_EN    = 3'd4;

	// Water kinds and the last biome
	localparam logic [1:0] WATER_RIVER = 2'd1;
	localparam logic [1:0] WATER_LAKE  = 2'd2;
	localparam logic [3:0] BIOME_BARE  = 4'd10;

	// floor(x / 10000) as (x * CH_RECIP) >> CH_SHIFT, exact for x below 2^22
	localparam logic [23:0] CH_RECIP = 24'd13743896;
	localparam int CH_SHIFT = 37;

	// Biome palette in hundredths, red green blue
	localparam logic [6:0] PALETTE [11][3] = '{
		'{7'd10, 7'd25, 7'd70}, '{7'd88, 7'd80, 7'd55}, '{7'd93, 7'd82, 7'd46},
		'{7'd65, 7'd72, 7'd25}, '{7'd25, 7'd65, 7'd30}, '{7'd50, 7'd60, 7'd40},
		'{7'd20, 7'd55, 7'd25}, '{7'd15, 7'd40, 7'd20}, '{7'd10, 7'd60, 7'd30},
		'{7'd70, 7'd75, 7'd80}, '{7'd50, 7'd50, 7'd50}
	};

	typedef struct packed {
		logic [10:0] grid_width;
		logic [12:0] grid_height;
		logic [15:0] xy_scale;
		logic [15:0] z_scale;
		logic        water_en;
	} cfg_t;

	// One unit of work for the back: an optional row write and an optional vertex
	typedef struct packed {
		logic             wr;
		logic [15:0]      hgt;
		logic [5:0]       attr;
		logic [1:0]       wslot;
		logic             wpar;
		logic [COL_W-1:0] wcol;
		logic             emit;
		logic [COL_W-1:0] x;
		logic [COL_W-1:0] xl;
		logic [COL_W-1:0] xr;
		logic [ROW_W-1:0] y;
		logic [1:0]       ys;
		logic [1:0]       yus;
		logic [1:0]       yds;
		logic             ypar;
		logic             last;
	} job_t;

	// Channel level in ten-thousandths, with optional water tint
	function automatic logic [13:0] tint_level(logic [6:0] p, logic [1:0] wk, logic en);
		logic [13:0] n;
		n = 14'(p) * 14'd100;
		if (en && wk == WATER_RIVER) begin
			n = 14'(p) * 14'd15 + 14'd1000;
		end else if (en && wk == WATER_LAKE) begin
			n = 14'(p) * 14'd10 + 14'd800;
		end
		return n;
	endfunction

endpackage

FILE: src/htvs_ram.sv
// ----------------------------------------------------------------------------
// htvs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module htvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/htvs_queue.sv
// ----------------------------------------------------------------------------
// htvs_queue
// Two-word job queue between the front and the back.
// ----------------------------------------------------------------------------
module htvs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  htvs_pkg::job_t push_word,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output htvs_pkg::job_t head
);
	import htvs_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[rp_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= push_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && head_valid) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && head_valid);
		end
	end

endmodule

FILE: src/htvs_front.sv
// ----------------------------------------------------------------------------
// htvs_front
// Holds the configuration and the raster counters, classifies each accepted
// word into a row write and/or a vertex job, and queues the job.
// ----------------------------------------------------------------------------
module htvs_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output htvs_pkg::cfg_t cfg,
	input  logic           sample_valid,
	output logic           sample_stall,
	input  logic           mode,
	input  logic [15:0]    height_sample,
	input  logic [3:0]     biome_code,
	input  logic [1:0]     water_kind,
	output logic           q_push,
	output htvs_pkg::job_t q_word,
	input  logic           q_full
);
	import htvs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = CW + 1;
	localparam int HW = RW + 1;

	cfg_t          cfg_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [1:0]    in_slot_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [1:0]    out_slot_q;
	logic          in_done_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          cfg_wr;
	logic          acc;
	logic          do_wr;
	logic          do_emit;
	logic          in_col_end;
	logic          in_row_end;
	logic          out_col_end;
	logic          out_row_end;
	logic          last;
	logic [1:0]    out_slot_prev;
	logic [1:0]    out_slot_next;
	job_t          job;

	assign cfg_ready    = 1'b1;
	assign cfg          = cfg_q;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign sample_stall = q_full;
	assign acc          = sample_valid && !q_full;

	// Clamp the geometry registers to the supported range
	always_comb begin
		if (cfg_q.grid_width == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(cfg_q.grid_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_q.grid_width);
		end
		if (cfg_q.grid_height == 13'd0) begin
			h_eff = HW'(1);
		end else if (32'(cfg_q.grid_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_q.grid_height);
		end
	end

	// Classify the word
	assign in_col_end  = ({1'b0, in_col_q} + WW'(1)) >= w_eff;
	assign in_row_end  = ({1'b0, in_row_q} + HW'(1)) >= h_eff;
	assign out_col_end = ({1'b0, out_col_q} + WW'(1)) >= w_eff;
	assign out_row_end = ({1'b0, out_row_q} + HW'(1)) >= h_eff;
	assign last        = out_row_end && out_col_end;
	assign do_wr       = acc && !mode && !in_done_q;
	assign do_emit     = acc && (mode ? in_done_q : (!in_done_q && in_row_q != '0));

	assign out_slot_prev = (out_slot_q == 2'd0) ? 2'd2 : out_slot_q - 2'd1;
	assign out_slot_next = (out_slot_q == 2'd2) ? 2'd0 : out_slot_q + 2'd1;

	// Build the job word with clamped neighbor positions
	always_comb begin
		job       = '0;
		job.wr    = do_wr;
		job.hgt   = height_sample;
		job.attr  = {water_kind, biome_code};
		job.wslot = in_slot_q;
		job.wpar  = in_row_q[0];
		job.wcol  = COL_W'(in_col_q);
		job.emit  = do_emit;
		job.x     = COL_W'(out_col_q);
		job.xl    = (out_col_q == '0) ? '0 : COL_W'(out_col_q - CW'(1));
		job.xr    = out_col_end ? COL_W'(out_col_q) : COL_W'(out_col_q + CW'(1));
		job.y     = ROW_W'(out_row_q);
		job.ys    = out_slot_q;
		job.yus   = (out_row_q == '0) ? out_slot_q : out_slot_prev;
		job.yds   = out_row_end ? out_slot_q : out_slot_next;
		job.ypar  = out_row_q[0];
		job.last  = last;
	end

	assign q_push = do_wr || do_emit;
	assign q_word = job;

	// Hold configuration, advance raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= 11'd1024;
			cfg_q.grid_height <= 13'd1024;
			cfg_q.xy_scale    <= 16'd256;
			cfg_q.z_scale     <= 16'd256;
			cfg_q.water_en    <= 1'b0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= 2'd0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= 2'd0;
			in_done_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH: begin
					cfg_q.grid_width <= cfg_data[10:0];
				end
				CFG_GRID_HEIGHT: begin
					cfg_q.grid_height <= cfg_data[12:0];
				end
				CFG_XY_SCALE: begin
					cfg_q.xy_scale <= cfg_data;
				end
				CFG_Z_SCALE: begin
					cfg_q.z_scale <= cfg_data;
				end
				CFG_WATER_EN: begin
					cfg_q.water_en <= cfg_data[0];
				end
				default: begin
				end
			endcase
			// Restart the frame on a geometry change
			if (cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_HEIGHT) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= 2'd0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= 2'd0;
				in_done_q  <= 1'b0;
			end
		end else begin
			if (do_wr) begin
				if (in_row_end && in_col_end) begin
					in_done_q <= 1'b1;
				end else if (in_col_end) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + RW'(1);
					in_slot_q <= (in_slot_q == 2'd2) ? 2'd0 : in_slot_q + 2'd1;
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (do_emit) begin
				if (last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= 2'd0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= 2'd0;
					in_done_q  <= 1'b0;
				end else if (out_col_end) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + RW'(1);
					out_slot_q <= out_slot_next;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

endmodule

FILE: src/htvs_back.sv
// ----------------------------------------------------------------------------
// htvs_back
// Executes queued jobs: row buffer writes, neighbor reads, position and
// slope products, square root and three divides for the unit normal, palette
// color, and the output register.
// ----------------------------------------------------------------------------
module htvs_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  htvs_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  htvs_pkg::job_t q_head,
	output logic           q_pop,
	output logic           vertex_valid,
	input  logic           vertex_stall,
	output logic [25:0]    pos_x,
	output logic [23:0]    pos_y,
	output logic [27:0]    pos_z,
	output logic [15:0]    normal_x,
	output logic [15:0]    normal_y,
	output logic [14:0]    normal_z,
	output logic [7:0]     red,
	output logic [7:0]     green,
	output logic [7:0]     blue,
	output logic           end_of_frame
);
	import htvs_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int HD  = 3 * MAX_WIDTH;
	localparam int HAW = $clog2(HD);
	localparam int AD  = 2 * MAX_WIDTH;
	localparam int AAW = $clog2(AD);

	typedef enum logic [3:0] {
		B_IDLE, B_WR, B_RD, B_MUL, B_MAG, B_SQR, B_SUM, B_ROOT, B_DSET, B_DIV, B_OUT
	} bstate_t;

	bstate_t            state_q;
	job_t               job_q;
	logic [4:0]         cnt_q;
	logic [1:0]         dsel_q;
	logic [15:0]        hv_q [5];
	logic [5:0]         attr_q;
	logic signed [33:0] hz_q;
	logic signed [33:0] a_q;
	logic signed [33:0] b_q;
	logic [27:0]        px_q;
	logic [31:0]        pz_q;
	logic [21:0]        cn_q [3];
	logic [23:0]        py_q;
	logic [30:0]        ua_q;
	logic [30:0]        ub_q;
	logic               half_q;
	logic               ax_neg_q;
	logic               bx_neg_q;
	logic [7:0]         col_q [3];
	logic [61:0]        sqa_q;
	logic [61:0]        sqb_q;
	logic [63:0]        sq_s_q;
	logic [63:0]        sq_res_q;
	logic [63:0]        sq_bit_q;
	logic [47:0]        rem_q;
	logic [47:0]        dsh_q;
	logic [15:0]        qt_q;
	logic [15:0]        nq_q [3];

	logic               ov_q;
	logic [25:0]        pos_x_q;
	logic [23:0]        pos_y_q;
	logic [27:0]        pos_z_q;
	logic [15:0]        normal_x_q;
	logic [15:0]        normal_y_q;
	logic [14:0]        normal_z_q;
	logic [7:0]         red_q;
	logic [7:0]         green_q;
	logic [7:0]         blue_q;
	logic               eof_q;

	logic               h_we;
	logic [HAW-1:0]     h_waddr;
	logic [HAW-1:0]     h_raddr;
	logic [15:0]        h_rdata;
	logic [AAW-1:0]     a_waddr;
	logic [AAW-1:0]     a_raddr;
	logic [5:0]         a_rdata;
	logic [1:0]         rslot;
	logic [CW-1:0]      rcol;

	logic signed [16:0] zs;
	logic signed [16:0] hc;
	logic signed [16:0] dha;
	logic signed [16:0] dhb;
	logic [3:0]         bsel;
	logic [33:0]        hz_mag;
	logic [33:0]        py_sum;
	logic [23:0]        py_mag;
	logic [33:0]        ua_full;
	logic [33:0]        ub_full;
	logic               big;
	logic [45:0]        cprod [3];
	logic [63:0]        sq_t;
	logic               sq_ge;
	logic [30:0]        dmag;
	logic               d_ge;
	logic [15:0]        qt_next;
	logic               out_free;

	// Row buffers
	htvs_ram #(.WIDTH(16), .DEPTH(HD)) u_hram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (job_q.hgt),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	htvs_ram #(.WIDTH(6), .DEPTH(AD)) u_aram (
		.clk   (clk),
		.we    (h_we),
		.waddr (a_waddr),
		.wdata (job_q.attr),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	assign h_we    = (state_q == B_WR) && job_q.wr;
	assign h_waddr = HAW'(job_q.wslot) * HAW'(MAX_WIDTH) + HAW'(job_q.wcol[CW-1:0]);
	assign a_waddr = AAW'(job_q.wpar) * AAW'(MAX_WIDTH) + AAW'(job_q.wcol[CW-1:0]);
	assign h_raddr = HAW'(rslot) * HAW'(MAX_WIDTH) + HAW'(rcol);
	assign a_raddr = AAW'(job_q.ypar) * AAW'(MAX_WIDTH) + AAW'(job_q.x[CW-1:0]);

	// Pick the neighbor read for this step: left, center, right, up, down
	always_comb begin
		rslot = job_q.ys;
		rcol  = job_q.x[CW-1:0];
		unique case (cnt_q[2:0])
			3'd0: rcol = job_q.xl[CW-1:0];
			3'd2: rcol = job_q.xr[CW-1:0];
			3'd3: rslot = job_q.yus;
			3'd4: rslot = job_q.yds;
			default: begin
			end
		endcase
	end

	// Products, magnitudes and color terms
	assign zs      = {1'b0, cfg.z_scale};
	assign hc      = {hv_q[1][15], hv_q[1]};
	assign dha     = {hv_q[2][15], hv_q[2]} - {hv_q[0][15], hv_q[0]};
	assign dhb     = {hv_q[4][15], hv_q[4]} - {hv_q[3][15], hv_q[3]};
	assign bsel    = (attr_q[3:0] > BIOME_BARE) ? BIOME_BARE : attr_q[3:0];
	assign hz_mag  = hz_q[33] ? 34'(-hz_q) : 34'(hz_q);
	assign py_sum  = hz_mag + 34'd128;
	// |h * z| >> 8 stays below 2^23, so no saturation is reached
	assign py_mag  = py_sum[31:8];
	assign ua_full = a_q[33] ? 34'(-a_q) : 34'(a_q);
	assign ub_full = b_q[33] ? 34'(-b_q) : 34'(b_q);
	assign big     = ua_full[31] || ub_full[31];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cprod[k] = 46'(cn_q[k]) * 46'(CH_RECIP);
		end
	end

	// One step of the digit-by-digit square root
	assign sq_t  = sq_res_q + sq_bit_q;
	assign sq_ge = sq_s_q >= sq_t;

	// One step of the restoring divide
	assign d_ge    = rem_q >= dsh_q;
	assign qt_next = {qt_q[14:0], d_ge};

	always_comb begin
		unique case (dsel_q)
			2'd0:    dmag = ua_q;
			2'd1:    dmag = ub_q;
			default: dmag = half_q ? 31'h10000 : 31'h20000;
		endcase
	end

	assign out_free = !ov_q || !vertex_stall;
	assign q_pop    = (state_q == B_IDLE) && q_valid;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			dsel_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			// Load a new word or drop the accepted one
			if (state_q == B_OUT && out_free) begin
				ov_q <= 1'b1;
			end else if (!vertex_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_WR;
					end
				end
				B_WR: begin
					cnt_q   <= '0;
					state_q <= job_q.emit ? B_RD : B_IDLE;
				end
				B_RD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) begin
						state_q <= B_MUL;
					end
				end
				B_MUL:  state_q <= B_MAG;
				B_MAG:  state_q <= B_SQR;
				B_SQR:  state_q <= B_SUM;
				B_SUM: begin
					cnt_q   <= '0;
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						dsel_q  <= 2'd0;
						state_q <= B_DSET;
					end
				end
				B_DSET: begin
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						if (dsel_q == 2'd2) begin
							state_q <= B_OUT;
						end else begin
							dsel_q  <= dsel_q + 2'd1;
							state_q <= B_DSET;
						end
					end
				end
				B_OUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					job_q <= q_head;
				end
			end
			B_RD: begin
				if (cnt_q != 5'd0) begin
					hv_q[cnt_q[2:0] - 3'd1] <= h_rdata;
				end
				if (cnt_q == 5'd1) begin
					attr_q <= a_rdata;
				end
			end
			B_MUL: begin
				hz_q <= hc * zs;
				a_q  <= dha * zs;
				b_q  <= dhb * zs;
				px_q <= 28'(job_q.x) * 28'(cfg.xy_scale);
				pz_q <= 32'(job_q.y) * 32'(cfg.xy_scale);
				for (int k = 0; k < 3; k++) begin
					cn_q[k] <= 22'(tint_level(PALETTE[bsel][k], attr_q[5:4], cfg.water_en))
						* 22'd255 + 22'd5000;
				end
			end
			B_MAG: begin
				py_q     <= hz_q[33] ? 24'(-py_mag) : py_mag;
				half_q   <= big;
				ua_q     <= big ? ua_full[31:1] : ua_full[30:0];
				ub_q     <= big ? ub_full[31:1] : ub_full[30:0];
				ax_neg_q <= !a_q[33] && (a_q != '0);
				bx_neg_q <= !b_q[33] && (b_q != '0);
				for (int k = 0; k < 3; k++) begin
					col_q[k] <= (cprod[k][45:CH_SHIFT] > 9'd255) ? 8'd255
						: cprod[k][CH_SHIFT+7:CH_SHIFT];
				end
			end
			B_SQR: begin
				sqa_q <= 62'(ua_q) * 62'(ua_q);
				sqb_q <= 62'(ub_q) * 62'(ub_q);
			end
			B_SUM: begin
				sq_s_q   <= 64'(sqa_q) + 64'(sqb_q) + (half_q ? 64'h1_0000_0000
					: 64'h4_0000_0000);
				sq_res_q <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			B_ROOT: begin
				if (sq_ge) begin
					sq_s_q   <= sq_s_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			B_DSET: begin
				// Numerator mag * 32768 + r, divisor 2r aligned to the top quotient bit
				rem_q <= {2'b00, dmag, 15'd0} + {16'd0, sq_res_q[31:0]};
				dsh_q <= {sq_res_q[31:0], 16'd0};
				qt_q  <= '0;
			end
			B_DIV: begin
				if (d_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				qt_q  <= qt_next;
				if (cnt_q == 5'd15) begin
					nq_q[dsel_q] <= qt_next;
				end
			end
			B_OUT: begin
				if (out_free) begin
					pos_x_q    <= px_q[25:0];
					pos_y_q    <= py_q;
					pos_z_q    <= pz_q[27:0];
					normal_x_q <= ax_neg_q ? 16'(16'd0 - nq_q[0]) : nq_q[0];
					normal_y_q <= bx_neg_q ? 16'(16'd0 - nq_q[1]) : nq_q[1];
					normal_z_q <= nq_q[2][14:0];
					red_q      <= col_q[0];
					green_q    <= col_q[1];
					blue_q     <= col_q[2];
					eof_q      <= job_q.last;
				end
			end
			default: begin
			end
		endcase
	end

	assign vertex_valid = ov_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign normal_x     = normal_x_q;
	assign normal_y     = normal_y_q;
	assign normal_z     = normal_z_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign end_of_frame = eof_q;

endmodule

FILE: src/heightmap_terrain_vertex_stream.sv
// ----------------------------------------------------------------------------
// heightmap_terrain_vertex_stream
// Raster height samples in, one terrain vertex (position, unit normal, color)
// per grid point out, one row behind the input; drain words flush the last row.
// ----------------------------------------------------------------------------
// A sample that yields no vertex passes the back through its idle and write states only.
// The back takes a new job only when idle; each vertex goes through the shared
// square root (32 steps) and the shared divider (3 quotients of 16 steps each).
// A two-word job queue lets the front accept while the back works.
// Reset clears counters and restores register defaults; row buffers are
// not cleared and need no clearing pass.
module heightmap_terrain_vertex_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        mode,
	input  logic [15:0] height_sample,
	input  logic [3:0]  biome_code,
	input  logic [1:0]  water_kind,
	output logic        vertex_valid,
	input  logic        vertex_stall,
	output logic [25:0] pos_x,
	output logic [23:0] pos_y,
	output logic [27:0] pos_z,
	output logic [15:0] normal_x,
	output logic [15:0] normal_y,
	output logic [14:0] normal_z,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        end_of_frame
);
	import htvs_pkg::*;

	cfg_t cfg;
	job_t q_word;
	job_t q_head;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;

	htvs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cfg           (cfg),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.mode          (mode),
		.height_sample (height_sample),
		.biome_code    (biome_code),
		.water_kind    (water_kind),
		.q_push        (q_push),
		.q_word        (q_word),
		.q_full        (q_full)
	);

	htvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (q_word),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	htvs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_frame (end_of_frame)
	);

endmodule

FILE: sim/htvs_checker.sv
// ----------------------------------------------------------------------------
// htvs_checker
// Watches the config, sample and vertex channels of the terrain vertex
// stream, predicts each vertex from the accepted samples and compares it.
// ----------------------------------------------------------------------------
module htvs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  logic        mode,
	input  logic [15:0] height_sample,
	input  logic [3:0]  biome_code,
	input  logic [1:0]  water_kind,
	input  logic        vertex_valid,
	input  logic        vertex_stall,
	input  logic [25:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [27:0] pos_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [14:0] normal_z,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        end_of_frame,
	output int          errors,
	output int          pending
);
	import htvs_pkg::*;

	localparam int ROW_SLOTS = 1024;
	localparam int MAX_ROWS  = 4096;

	typedef struct packed {
		logic [25:0] px;
		logic [23:0] py;
		logic [27:0] pz;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [14:0] nz;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        eof;
	} vertex_t;

	// Palette in hundredths
	localparam int BIOME_RGB [11][3] = '{
		'{10, 25, 70}, '{88, 80, 55}, '{93, 82, 46}, '{65, 72, 25},
		'{25, 65, 30}, '{50, 60, 40}, '{20, 55, 25}, '{15, 40, 20},
		'{10, 60, 30}, '{70, 75, 80}, '{50, 50, 50}
	};

	logic [15:0] height_mem [0:3*ROW_SLOTS-1];
	logic [5:0]  attr_mem   [0:2*ROW_SLOTS-1];
	int unsigned wr_col, wr_row, vx_col, vx_row;
	bit          frame_loaded;
	int unsigned grid_w, grid_h, xy_sc, z_sc;
	bit          water_on;
	vertex_t     expected_vertices [$];

	function automatic int unsigned width_used();
		return grid_w < 1 ? 1 : (grid_w > ROW_SLOTS ? ROW_SLOTS : grid_w);
	endfunction

	function automatic int unsigned height_used();
		return grid_h < 1 ? 1 : (grid_h > MAX_ROWS ? MAX_ROWS : grid_h);
	endfunction

	function automatic longint height_at(int unsigned col, int unsigned row);
		logic [15:0] v;
		v = height_mem[(row % 3) * ROW_SLOTS + col];
		return longint'($signed(v));
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > s) bt = bt >> 2;
		while (bt != 0) begin
			if (s >= res + bt) begin
				s = s - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Rounded quotient mag * 2^14 / len, negated when asked
	function automatic logic [15:0] unit_comp(logic [63:0] mag, bit neg, logic [63:0] len);
		logic [63:0] q;
		q = (2 * mag * 16384 + len) / (2 * len);
		return neg ? 16'(0 - q) : 16'(q);
	endfunction

	function automatic logic [7:0] tinted(int unsigned p, int unsigned wk);
		int unsigned n, v;
		n = 100 * p;
		if (water_on && wk == WATER_RIVER) n = 15 * p + 1000;
		else if (water_on && wk == WATER_LAKE) n = 10 * p + 800;
		v = (255 * n + 5000) / 10000;
		return v > 255 ? 8'd255 : 8'(v);
	endfunction

	function automatic void restart_frame();
		wr_col = 0; wr_row = 0; vx_col = 0; vx_row = 0; frame_loaded = 0;
	endfunction

	// Build the vertex at the output cursor and advance the cursor
	function automatic void queue_vertex();
		int unsigned w, h, x, y, xl, xr, yu, yd, biome, wk;
		longint hz, py, da, db;
		logic [63:0] mag, ua, ub, c, len;
		logic [5:0] at;
		vertex_t v;
		bit last;
		w = width_used(); h = height_used();
		x = vx_col; y = vx_row;
		xl = x > 0 ? x - 1 : 0;
		xr = x + 1 < w ? x + 1 : w - 1;
		yu = y > 0 ? y - 1 : 0;
		yd = y + 1 < h ? y + 1 : h - 1;
		hz = height_at(x, y) * longint'(z_sc);
		mag = hz < 0 ? -hz : hz;
		py = longint'((mag + 128) >> 8);
		if (hz < 0) py = -py;
		if (py > 8388607) py = 8388607;
		if (py < -8388608) py = -8388608;
		da = (height_at(xr, y) - height_at(xl, y)) * longint'(z_sc);
		db = (height_at(x, yd) - height_at(x, yu)) * longint'(z_sc);
		ua = da < 0 ? -da : da;
		ub = db < 0 ? -db : db;
		c = 64'd1 << 17;
		if ((ua > ub ? ua : ub) >= (64'd1 << 31)) begin
			ua = ua >> 1; ub = ub >> 1; c = c >> 1;
		end
		len = int_sqrt(ua * ua + ub * ub + c * c);
		at = attr_mem[(y & 1) * ROW_SLOTS + x];
		biome = at[3:0];
		wk = at[5:4];
		if (biome > BIOME_BARE) biome = BIOME_BARE;
		last = (y + 1 >= h) && (x + 1 >= w);
		v.px  = 26'(longint'(x) * xy_sc);
		v.py  = 24'(py);
		v.pz  = 28'(longint'(y) * xy_sc);
		v.nx  = unit_comp(ua, da > 0, len);
		v.ny  = unit_comp(ub, db > 0, len);
		v.nz  = 15'(unit_comp(c, 0, len));
		v.r   = tinted(BIOME_RGB[biome][0], wk);
		v.g   = tinted(BIOME_RGB[biome][1], wk);
		v.b   = tinted(BIOME_RGB[biome][2], wk);
		v.eof = last;
		expected_vertices.insert(expected_vertices.size(), v);
		if (last) begin
			restart_frame();
		end else if (++vx_col >= w) begin
			vx_col = 0;
			vx_row++;
		end
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t vertex mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) report(what, got, want);
	endtask

	always @(posedge clk) begin
		vertex_t v;
		int unsigned w, h, col, row;
		if (!arst_n) begin
			restart_frame();
			grid_w = 1024; grid_h = 1024; xy_sc = 256; z_sc = 256; water_on = 0;
			expected_vertices.delete();
			errors = 0;
		end else begin
			// Compare an accepted vertex with the oldest prediction
			if (vertex_valid && !vertex_stall) begin
				if (expected_vertices.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					v = expected_vertices.pop_front();
					compare_field("pos_x", pos_x, v.px);
					compare_field("pos_y", pos_y, v.py);
					compare_field("pos_z", pos_z, v.pz);
					compare_field("normal_x", normal_x, v.nx);
					compare_field("normal_y", normal_y, v.ny);
					compare_field("normal_z", normal_z, v.nz);
					compare_field("red", red, v.r);
					compare_field("green", green, v.g);
					compare_field("blue", blue, v.b);
					compare_field("end_of_frame", end_of_frame, v.eof);
				end
			end
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_GRID_WIDTH: begin
						grid_w = cfg_data[10:0];
						restart_frame();
					end
					CFG_GRID_HEIGHT: begin
						grid_h = cfg_data[12:0];
						restart_frame();
					end
					CFG_XY_SCALE: xy_sc = cfg_data;
					CFG_Z_SCALE:  z_sc = cfg_data;
					CFG_WATER_EN: water_on = cfg_data[0];
					default: ;
				endcase
			end
			// Store a sample or drain one vertex
			if (sample_valid && !sample_stall) begin
				w = width_used(); h = height_used();
				col = wr_col; row = wr_row;
				if (mode) begin
					if (frame_loaded) queue_vertex();
				end else if (!frame_loaded) begin
					height_mem[(row % 3) * ROW_SLOTS + col] = height_sample;
					attr_mem[(row & 1) * ROW_SLOTS + col] = {water_kind, biome_code};
					if (row + 1 >= h && col + 1 >= w) begin
						frame_loaded = 1;
					end else if (++wr_col >= w) begin
						wr_col = 0;
						wr_row++;
					end
					if (row >= 1) queue_vertex();
				end
			end
		end
		pending <= expected_vertices.size();
	end

endmodule

FILE: sim/heightmap_terrain_vertex_stream_tb.sv
// ----------------------------------------------------------------------------
// heightmap_terrain_vertex_stream_tb
// Drives register writes and sample/drain words into the terrain vertex
// stream under random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module heightmap_terrain_vertex_stream_tb;
	import htvs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic        mode = 1'b0;
	logic [15:0] height_sample = '0;
	logic [3:0]  biome_code = '0;
	logic [1:0]  water_kind = '0;
	logic        vertex_valid;
	logic        vertex_stall = 1'b0;
	logic [25:0] pos_x;
	logic [23:0] pos_y;
	logic [27:0] pos_z;
	logic [15:0] normal_x;
	logic [15:0] normal_y;
	logic [14:0] normal_z;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        end_of_frame;
	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;

	heightmap_terrain_vertex_stream DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.mode(mode), .height_sample(height_sample),
		.biome_code(biome_code), .water_kind(water_kind),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.red(red), .green(green), .blue(blue), .end_of_frame(end_of_frame)
	);

	htvs_checker u_checker (.*);

	always #5 clk = ~clk;

	// Stall the vertex side at random
	always @(negedge clk) begin
		vertex_stall <= ($urandom_range(99) < stall_pct);
	end

	// Hard stop
	initial begin
		#20000000;
		$display("** heightmap_terrain_vertex_stream: FAILED **");
		$finish;
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one word, idling at random first, and hold it until taken
	task automatic send_word(logic m, logic [15:0] h, logic [3:0] b, logic [1:0] wk);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid  <= 1'b1;
		mode          <= m;
		height_sample <= h;
		biome_code    <= b;
		water_kind    <= wk;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Drained, then give the back time to finish rowless work
	task automatic settle();
		wait_drained();
		repeat (200) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_height();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_random();
		send_word(1'b0, pick_height(), 4'($urandom), 2'($urandom));
	endtask

	task automatic drain_random();
		send_word(1'b1, pick_height(), 4'($urandom), 2'($urandom));
	endtask

	// One full frame with random content and stray words that are dropped
	task automatic run_frame(int w, int h, bit mid_write);
		settle();
		write_reg(CFG_GRID_WIDTH, 16'(w));
		write_reg(CFG_GRID_HEIGHT, 16'(h));
		write_reg(CFG_XY_SCALE, pick_scale());
		write_reg(CFG_Z_SCALE, pick_scale());
		write_reg(CFG_WATER_EN, 16'($urandom_range(1)));
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(15) == 0) drain_random();
			if (mid_write && i == (w * h) / 2) begin
				settle();
				write_reg(CFG_Z_SCALE, pick_scale());
				write_reg(CFG_WATER_EN, 16'($urandom_range(1)));
			end
			push_random();
		end
		for (int j = 0; j < w; j++) begin
			if ($urandom_range(7) == 0) push_random();
			drain_random();
		end
	endtask

	initial begin
		int n, w, h;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_pct = 33;
		stall_pct = 58;

		// Extreme scales and heights: slopes large enough to halve
		write_reg(CFG_GRID_WIDTH, 16'd3);
		write_reg(CFG_GRID_HEIGHT, 16'd3);
		write_reg(CFG_XY_SCALE, 16'hFFFF);
		write_reg(CFG_Z_SCALE, 16'hFFFF);
		write_reg(CFG_WATER_EN, 16'd1);
		send_word(1'b1, 16'h1234, 4'd0, 2'd0);
		for (int i = 0; i < 9; i++) begin
			send_word(1'b0, (i % 2) ? 16'h8000 : 16'h7FFF, 4'((i * 7) % 16), 2'(i % 4));
		end
		send_word(1'b0, 16'h5555, 4'd15, 2'd3);
		for (int j = 0; j < 3; j++) send_word(1'b1, 16'hAAAA, 4'd11, 2'd3);

		// Zero geometry clamps to a single point; zero scales
		settle();
		write_reg(CFG_GRID_WIDTH, 16'd0);
		write_reg(CFG_GRID_HEIGHT, 16'd0);
		write_reg(CFG_XY_SCALE, 16'd0);
		write_reg(CFG_Z_SCALE, 16'd0);
		write_reg(CFG_WATER_EN, 16'd0);
		send_word(1'b0, 16'h8000, 4'd10, 2'd2);
		send_word(1'b1, 16'h0000, 4'd0, 2'd0);

		// Widest row, cut short by a geometry write mid-frame
		settle();
		write_reg(CFG_XY_SCALE, 16'hFFFF);
		write_reg(CFG_Z_SCALE, 16'd256);
		write_reg(CFG_GRID_WIDTH, 16'd2047);
		write_reg(CFG_GRID_HEIGHT, 16'd3);
		for (int i = 0; i < 40; i++) push_random();
		settle();
		write_reg(CFG_GRID_HEIGHT, 16'd8191);
		for (int i = 0; i < 20; i++) push_random();

		// Random frames, mostly small
		n = 0;
		while (n < 620) begin
			if (n < 205) begin
				idle_pct = 33; stall_pct = 58;
			end else if (n < 410) begin
				idle_pct = 58; stall_pct = 33;
			end else begin
				idle_pct = 0; stall_pct = 0;
			end
			if ($urandom_range(9) == 0) begin
				w = $urandom_range(9, 40);
				h = $urandom_range(1, 2);
			end else begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end
			if ($urandom_range(7) == 0) wait_drained();
			run_frame(w, h, $urandom_range(3) == 0);
			n += w * h + w;
		end

		wait_drained();
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("** heightmap_terrain_vertex_stream: PASSED **");
		end else begin
			$display("** heightmap_terrain_vertex_stream: FAILED **");
		end
		$finish;
	end

endmodule
